// File: hw/rtl/tilt_kalman_filter_step_core_macros.svh
// Assertion helpers for the tilt filter checker.
`ifndef TILT_KALMAN_FILTER_STEP_CORE_MACROS_SVH
`define TILT_KALMAN_FILTER_STEP_CORE_MACROS_SVH

// Implication checked every clock, disabled in reset.
`define TKF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked every clock, disabled in reset.
`define TKF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tkf_pkg.sv
`timescale 1ns / 1ps
package tkf_pkg;
    localparam int unsigned FRAC_BITS_DEF = 6;
    localparam int unsigned DATA_W = 16;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP     = 2'd0,
        CFG_INPUT_GAIN    = 2'd1,
        CFG_MEASURE_NOISE = 2'd2,
        CFG_PROCESS_NOISE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] gyro_rate;
        logic signed [DATA_W-1:0] tilt_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] predicted_angle;
        logic signed [DATA_W-1:0] innovation;
        logic signed [DATA_W-1:0] innovation_variance;
        logic signed [DATA_W-1:0] projected_cov;
        logic signed [DATA_W-1:0] angle_gain;
        logic signed [DATA_W-1:0] updated_angle;
        logic                     divide_fault;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [DATA_W-1:0]    data;
    } t_cfg_beat;

    // divider handshake
    typedef struct packed {
        logic start;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;
endpackage

// File: hw/rtl/tkf_stream_if.sv
`timescale 1ns / 1ps
interface tkf_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/tkf_divider.sv
`timescale 1ns / 1ps
// Restoring signed divider, one quotient bit a cycle, truncates toward zero.
module tkf_divider
    import tkf_pkg::*;
#(
    parameter int unsigned NUM_W = 32,
    parameter int unsigned DEN_W = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_div_req                i_req,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    output t_div_sts                o_sts,
    output logic signed [NUM_W-1:0] o_quo
);
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic             r_neg, n_neg;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W+1:0] w_diff;
    logic [NUM_W-1:0] w_anum;

    always_comb begin
        w_anum = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        w_trial = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
        w_diff = {1'b0, w_trial} - {2'b00, r_den};
        n_quo = r_quo;
        n_rem = r_rem;
        n_den = r_den;
        n_neg = r_neg;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo = w_anum;
            n_rem = '0;
            n_den = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
            n_neg = i_num[NUM_W-1] ^ i_den[DEN_W-1];
            n_cnt = CNT_W'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[DEN_W+1]) begin
                n_rem = w_diff[DEN_W:0];
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_quo = r_neg ? -$signed(r_quo) : $signed(r_quo);
    assign o_sts = '{busy: r_busy, done: r_done};
endmodule

// File: hw/rtl/tilt_kalman_filter_step_core.sv
`timescale 1ns / 1ps
// Two-state tilt Kalman filter step in fixed point (FRAC_BITS fraction bits).
// Each input beat carries one gyro rate and one tilt sample; each produces
// one result beat with the predicted angle, innovation, innovation variance,
// projected covariance, angle gain, corrected angle and a divide fault flag.
// A step runs on a sequencer that drives one shared 32x16 signed multiplier
// and one bit-serial divider. A step issues 14 products through one pipeline
// stage, with one hazard stall before each of steps 9 and 13, and two
// divisions of FRAC_BITS + 18 quotient bits each (24 with the default 6
// fraction bits). The next input beat is taken in the cycle after the result
// beat is taken. The input is not ready while a step runs or while a result
// waits to be taken. Configuration writes are taken at any time and should
// be made only while the block is idle.
module tilt_kalman_filter_step_core
    import tkf_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tkf_stream_if.sink   s_in,
    tkf_stream_if.sink   s_cfg,
    tkf_stream_if.source m_out
);
    localparam int unsigned W = DATA_W;
    localparam int unsigned MA_W = 2 * W;     // wide multiplier operand
    localparam int unsigned PW = MA_W + W;    // product width
    localparam int unsigned QW = W + FRAC_BITS + 2; // divider numerator width

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL   = 8'b0000_0010,
        ST_DIVA  = 8'b0000_0100,
        ST_WAITA = 8'b0000_1000,
        ST_DIVB  = 8'b0001_0000,
        ST_WAITB = 8'b0010_0000,
        ST_UPD   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } t_state;

    // Configuration and filter state.
    logic signed [W-1:0] r_dt, r_gain, r_mnoise, r_pnoise;
    logic signed [W-1:0] r_ang, r_sec, r_paa, r_pab, r_pba, r_pbb;

    // Step working values.
    logic signed [W-1:0] r_gyro, r_tilt;
    logic signed [W-1:0] r_pred, r_inn, r_var, r_ap00, r_ap01, r_ka, r_kb;
    logic signed [W+1:0] r_acc;     // running truncated-term sum
    logic signed [PW-1:0] r_prod;   // registered multiplier output
    logic signed [MA_W-1:0] r_tmp;  // truncated products feeding later steps
    logic                r_fault;
    t_out_item           r_res;
    t_state              r_state;
    logic [4:0]          r_step;
    logic                r_pvld;    // r_prod holds the product of step r_step-1

    // Multiplier operand select, one product per step.
    logic signed [MA_W-1:0] w_ma;
    logic signed [W-1:0]    w_mb;
    logic signed [PW-1:0]   w_prod, w_tp;
    logic signed [PW-1:0]   w_tr;
    logic [4:0]             w_rs;     // step whose product is in r_prod

    localparam logic [4:0] NSTEP = 5'd14;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_step)
            5'd0:  begin w_ma = MA_W'(r_dt);   w_mb = r_sec;  end
            5'd1:  begin w_ma = MA_W'(r_gain); w_mb = r_gyro; end
            5'd2:  begin w_ma = MA_W'(r_dt);   w_mb = r_pba;  end
            5'd3:  begin w_ma = MA_W'(r_dt);   w_mb = r_pbb;  end
            // after the divisions; second row first so it still reads the first
            // row's covariance from before this step
            5'd4:  begin w_ma = MA_W'(r_ka);   w_mb = r_inn;  end
            5'd5:  begin w_ma = MA_W'(r_kb);   w_mb = r_inn;  end
            5'd6:  begin w_ma = MA_W'(r_pbb);  w_mb = r_dt;   end
            5'd7:  begin w_ma = MA_W'(r_kb);   w_mb = r_paa;  end
            5'd8:  begin w_ma = MA_W'(r_kb);   w_mb = r_pab;  end
            5'd9:  begin w_ma = r_tmp;         w_mb = r_dt;   end
            5'd10: begin w_ma = MA_W'(r_ap01); w_mb = r_dt;   end
            5'd11: begin w_ma = MA_W'(r_ka);   w_mb = r_paa;  end
            5'd12: begin w_ma = MA_W'(r_ka);   w_mb = r_pab;  end
            5'd13: begin w_ma = r_tmp;         w_mb = r_dt;   end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
        w_prod = PW'(w_ma) * PW'(w_mb);
    end

    // Truncate toward zero: add (2^F - 1) to negatives before the shift.
    function automatic logic signed [PW-1:0] f_trunc(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] b;
        b = v[PW-1] ? v + PW'((1 << FRAC_BITS) - 1) : v;
        return b >>> FRAC_BITS;
    endfunction

    assign w_rs = r_step - 5'd1;
    assign w_tp = r_prod;
    assign w_tr = f_trunc(w_tp);

    // Held first term of each difference pair.
    logic signed [PW-1:0] r_hold;

    // Divider.
    t_div_req                w_dreq;
    t_div_sts                w_dsts;
    logic signed [QW-1:0]    w_dnum;
    logic signed [QW-1:0]    w_dquo;

    assign w_dreq.start = (r_state == ST_DIVA) || (r_state == ST_DIVB);
    assign w_dnum = (r_state == ST_DIVA) ? (QW'(r_ap00) <<< FRAC_BITS)
                                         : (QW'(r_pba) <<< FRAC_BITS);

    tkf_divider #(.NUM_W(QW), .DEN_W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .i_num   (w_dnum),
        .i_den   (r_var),
        .o_sts   (w_dsts),
        .o_quo   (w_dquo)
    );

    assign s_in.ready  = (r_state == ST_IDLE);
    assign s_cfg.ready = 1'b1;
    assign m_out.valid = (r_state == ST_OUT);
    assign m_out.payload = r_res;

    logic signed [PW-1:0] w_sum;

    always_ff @(posedge i_clk) begin
        // Configuration writes.
        if (!i_rst_n) begin
            r_dt     <= W'(1);
            r_gain   <= W'(1);
            r_mnoise <= W'(6);
            r_pnoise <= W'(1);
        end else if (s_cfg.valid) begin
            case (t_cfg_idx'(s_cfg.payload.index))
                CFG_TIME_STEP:     r_dt     <= s_cfg.payload.data;
                CFG_INPUT_GAIN:    r_gain   <= s_cfg.payload.data;
                CFG_MEASURE_NOISE: r_mnoise <= s_cfg.payload.data;
                CFG_PROCESS_NOISE: r_pnoise <= s_cfg.payload.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_sum = '0;
        w_sum = r_hold - w_tp;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_pvld  <= 1'b0;
            r_ang   <= '0;
            r_sec   <= '0;
            r_paa   <= W'(64);
            r_pab   <= '0;
            r_pba   <= '0;
            r_pbb   <= W'(64);
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (s_in.valid) begin
                        r_gyro  <= s_in.payload.gyro_rate;
                        r_tilt  <= s_in.payload.tilt_angle;
                        r_step  <= 5'd0;
                        r_pvld  <= 1'b0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    // Issue product r_step; consume the one issued last cycle.
                    if (r_pvld) begin
                        case (w_rs)
                            5'd0: r_acc <= (W+2)'(r_ang) + (W+2)'(w_tr);
                            5'd1: begin
                                r_pred <= W'(r_acc + (W+2)'(w_tr));
                                r_inn  <= W'(r_tilt - W'(r_acc + (W+2)'(w_tr)));
                                r_var  <= r_paa + r_mnoise;
                            end
                            5'd2: r_ap00 <= W'(r_paa + W'(w_tr));
                            5'd3: begin
                                r_ap01 <= W'(r_pab + W'(w_tr));
                                r_state <= ST_DIVA;
                            end
                            5'd4: r_res.updated_angle <= W'(r_pred + W'(w_tr));
                            5'd5: r_sec <= W'(r_sec + W'(w_tr));
                            5'd6: r_hold <= w_tp;
                            5'd7: r_acc <= (W+2)'(f_trunc(w_sum));
                            5'd8: begin
                                r_tmp <= MA_W'(w_tr);
                                r_pbb <= W'(r_pbb - W'(w_tr));
                            end
                            5'd9: r_pba <= W'(r_pba + W'(r_acc) - W'(w_tr));
                            5'd10: r_hold <= w_tp;
                            5'd11: r_acc <= (W+2)'(f_trunc(w_sum));
                            5'd12: begin
                                r_tmp <= MA_W'(w_tr);
                                r_pab <= W'(r_ap01 - W'(w_tr));
                            end
                            5'd13: begin
                                r_paa <= W'(r_ap00 + W'(r_acc) - W'(w_tr) + r_pnoise);
                                r_ang <= r_res.updated_angle;
                                r_res.predicted_angle <= r_pred;
                                r_res.innovation <= r_inn;
                                r_res.innovation_variance <= r_var;
                                r_res.projected_cov <= r_ap00;
                                r_res.angle_gain <= r_ka;
                                r_res.divide_fault <= r_fault;
                                r_state <= ST_OUT;
                            end
                            default: ;
                        endcase
                    end
                    // Steps 8 and 12 feed step 9 and 13: stall one issue.
                    if (r_pvld && (r_step == 5'd9 || r_step == 5'd13)) begin
                        r_pvld <= 1'b0;
                    end else begin
                        r_pvld <= 1'b1;
                        if (r_step < NSTEP) r_step <= r_step + 5'd1;
                    end
                end
                ST_DIVA: begin
                    r_fault <= (r_var == '0);
                    r_state <= ST_WAITA;
                end
                ST_WAITA: begin
                    if (w_dsts.done) begin
                        r_ka <= r_fault ? '0 : W'(w_dquo);
                        r_state <= ST_DIVB;
                    end
                end
                ST_DIVB: r_state <= ST_WAITB;
                ST_WAITB: begin
                    if (w_dsts.done) begin
                        r_kb <= r_fault ? '0 : W'(w_dquo);
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    // Restart the multiply sequence at the correction steps.
                    r_step  <= 5'd4;
                    r_pvld  <= 1'b0;
                    r_state <= ST_MUL;
                end
                ST_OUT: begin
                    if (m_out.ready) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/tkf_checker.sv
`timescale 1ns / 1ps
`include "tilt_kalman_filter_step_core_macros.svh"
// Port-level checks for the tilt filter core.
module tkf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    // One step at a time: no new input while a result is pending.
    `TKF_ASSERT_IMPL(a_no_in_while_out, i_clk, i_rst_n, out_valid, !in_ready, "input ready during result")
    // Acceptance starts a step: input closes next cycle.
    `TKF_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, in_valid && in_ready, !in_ready && !out_valid, "step not started")
    // A result held until taken.
    `TKF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid, "result dropped")
endmodule

bind tilt_kalman_filter_step_core tkf_checker u_tkf_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (s_in.valid),
    .in_ready  (s_in.ready),
    .out_valid (m_out.valid),
    .out_ready (m_out.ready)
);
